FILE: sv/hrlc_pkg.sv
// Package: item types, error kinds and a saturating count helper for the layout checker.
`timescale 1ns / 1ps

package hrlc_pkg;

    localparam int CountW = 7;
    localparam int HashW  = 32;

    typedef logic [CountW-1:0] t_count;
    typedef logic [HashW-1:0]  t_hash;

    // Error kind of one layout entry
    typedef enum logic [2:0] {
        KIND_OK        = 3'd0,
        KIND_NOT_FOUND = 3'd1,
        KIND_UNKNOWN   = 3'd2,
        KIND_STALE     = 3'd3,
        KIND_NOT_CONN  = 3'd4,
        KIND_NO_SPACE  = 3'd5,
        KIND_OTHER     = 3'd6,
        KIND_UNDEF     = 3'd7
    } t_kind;

    localparam t_count     COUNT_MAX   = {CountW{1'b1}};
    localparam logic [7:0] VERDICT_BAD = 8'hFF;

    typedef struct packed {
        t_kind err_kind;
        t_hash range_start;
        t_hash range_stop;
        logic  last_entry;
    } t_in_item;

    typedef struct packed {
        t_count      hole_count;
        t_count      overlap_count;
        t_count      missing_count;
        t_count      down_count;
        t_count      misc_count;
        t_count      no_space_count;
        t_count      missing_dir_count;
        logic signed [7:0] verdict;
    } t_out_item;

    // Saturating increment
    function automatic t_count sat_inc(input t_count c, input logic en);
        sat_inc = (en && (c != COUNT_MAX)) ? c + t_count'(1) : c;
    endfunction

endpackage

FILE: sv/hash_range_layout_check_unit.sv
// Top level of the hash-range layout checker: input register, tracking logic, result register.
`timescale 1ns / 1ps

// Takes one sorted layout entry per item and gives one result item with all counts
// and the verdict when the entry marked last has been taken. An item can be accepted
// every cycle while o_in_stall is low. The last entry is first taken by the input
// register when accepted; the result register then takes the counts, after the single
// pass of compares and saturating increments, when the entry is free to move on.
// A waiting result does not block the input while the result register can
// still be emptied; o_in_stall rises only when a registered entry cannot move on
// because an undelivered result is stalled.

module hash_range_layout_check_unit import hrlc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item res;
    logic      advance;
    logic      proc_en;
    logic      in_take;

    // Stage two may move when the result register is free or being drained
    assign advance    = !(r_out_valid && i_out_stall);
    assign proc_en    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    hrlc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_en),
        .i_item  (r_in_item),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc_en && r_in_item.last_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && r_in_item.last_entry) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_verdict_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.hole_count != '0) || (o_out_item.overlap_count != '0))
        |-> o_out_item.verdict == VERDICT_BAD)
        else $error("verdict not -1 with holes or overlaps");

    a_verdict_dirs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.hole_count == '0) && (o_out_item.overlap_count == '0)
        |-> o_out_item.verdict == {1'b0, o_out_item.missing_dir_count})
        else $error("verdict does not match missing directory count");

    a_dirs_le_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.missing_dir_count <= o_out_item.missing_count)
        else $error("missing directory count exceeds missing count");

    a_stall_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule

FILE: sv/hrlc_track.sv
// Layout tracking state: running counts, previous stop and wrap check, result on the last item.
`timescale 1ns / 1ps

module hrlc_track import hrlc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    output t_out_item o_res
);

    logic   r_expect_first, n_expect_first;
    t_hash  r_wrap_stop,    n_wrap_stop;
    t_hash  r_prev_stop,    n_prev_stop;
    logic   r_no_range,     n_no_range;
    t_count r_holes,        n_holes;
    t_count r_overlaps,     n_overlaps;
    t_count r_missing,      n_missing;
    t_count r_down,         n_down;
    t_count r_misc,         n_misc;
    t_count r_no_space,     n_no_space;
    t_count r_missing_dirs, n_missing_dirs;

    // Per-item update
    always_comb begin
        t_hash  wrap_eff;
        t_hash  prev_eff;
        t_hash  want;
        logic   ranged;
        logic   no_range_upd;
        t_hash  prev_upd;
        t_count holes_upd;
        t_count holes_fin;
        t_count overlaps_upd;
        t_count missing_upd;
        t_count down_upd;
        t_count misc_upd;
        t_count no_space_upd;
        t_count dirs_upd;
        logic   final_hole;

        // first entry seeds wrap and previous stop
        wrap_eff = r_expect_first ? i_item.range_start - t_hash'(1) : r_wrap_stop;
        prev_eff = r_expect_first ? i_item.range_start - t_hash'(1) : r_prev_stop;
        want     = prev_eff + t_hash'(1);
        ranged   = (i_item.err_kind == KIND_OK) &&
                   (i_item.range_start != i_item.range_stop);

        no_range_upd = r_no_range && !ranged;
        prev_upd     = ranged ? i_item.range_stop : prev_eff;
        holes_upd    = sat_inc(r_holes, ranged && (want < i_item.range_start));
        overlaps_upd = sat_inc(r_overlaps, ranged && (want > i_item.range_start));

        missing_upd  = sat_inc(r_missing, (i_item.err_kind == KIND_NOT_FOUND) ||
                                          (i_item.err_kind == KIND_UNKNOWN) ||
                                          (i_item.err_kind == KIND_STALE));
        dirs_upd     = sat_inc(r_missing_dirs, (i_item.err_kind == KIND_NOT_FOUND) ||
                                ((i_item.err_kind == KIND_UNKNOWN) &&
                                 (i_item.range_start == '0) && (i_item.range_stop == '0)));
        down_upd     = sat_inc(r_down, i_item.err_kind == KIND_NOT_CONN);
        no_space_upd = sat_inc(r_no_space, i_item.err_kind == KIND_NO_SPACE);
        misc_upd     = sat_inc(r_misc, (i_item.err_kind == KIND_OTHER) ||
                                       (i_item.err_kind == KIND_UNDEF));

        // wrap check and empty layout add a final hole
        final_hole = (wrap_eff != prev_upd) || no_range_upd;
        holes_fin  = sat_inc(holes_upd, final_hole);

        o_res.hole_count        = holes_fin;
        o_res.overlap_count     = overlaps_upd;
        o_res.missing_count     = missing_upd;
        o_res.down_count        = down_upd;
        o_res.misc_count        = misc_upd;
        o_res.no_space_count    = no_space_upd;
        o_res.missing_dir_count = dirs_upd;
        o_res.verdict = ((holes_fin != '0) || (overlaps_upd != '0)) ?
                        VERDICT_BAD : {1'b0, dirs_upd};

        // hold, advance, or return to reset after the last entry
        n_expect_first = r_expect_first;
        n_wrap_stop    = r_wrap_stop;
        n_prev_stop    = r_prev_stop;
        n_no_range     = r_no_range;
        n_holes        = r_holes;
        n_overlaps     = r_overlaps;
        n_missing      = r_missing;
        n_down         = r_down;
        n_misc         = r_misc;
        n_no_space     = r_no_space;
        n_missing_dirs = r_missing_dirs;
        if (i_en && i_item.last_entry) begin
            n_expect_first = 1'b1;
            n_wrap_stop    = '0;
            n_prev_stop    = '0;
            n_no_range     = 1'b1;
            n_holes        = '0;
            n_overlaps     = '0;
            n_missing      = '0;
            n_down         = '0;
            n_misc         = '0;
            n_no_space     = '0;
            n_missing_dirs = '0;
        end else if (i_en) begin
            n_expect_first = 1'b0;
            n_wrap_stop    = wrap_eff;
            n_prev_stop    = prev_upd;
            n_no_range     = no_range_upd;
            n_holes        = holes_upd;
            n_overlaps     = overlaps_upd;
            n_missing      = missing_upd;
            n_down         = down_upd;
            n_misc         = misc_upd;
            n_no_space     = no_space_upd;
            n_missing_dirs = dirs_upd;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
            r_wrap_stop    <= '0;
            r_prev_stop    <= '0;
            r_no_range     <= 1'b1;
            r_holes        <= '0;
            r_overlaps     <= '0;
            r_missing      <= '0;
            r_down         <= '0;
            r_misc         <= '0;
            r_no_space     <= '0;
            r_missing_dirs <= '0;
        end else begin
            r_expect_first <= n_expect_first;
            r_wrap_stop    <= n_wrap_stop;
            r_prev_stop    <= n_prev_stop;
            r_no_range     <= n_no_range;
            r_holes        <= n_holes;
            r_overlaps     <= n_overlaps;
            r_missing      <= n_missing;
            r_down         <= n_down;
            r_misc         <= n_misc;
            r_no_space     <= n_no_space;
            r_missing_dirs <= n_missing_dirs;
        end
    end

endmodule

FILE: test/hash_range_layout_check_unit_tb.sv
// Testbench for the hash-range layout checker: layout stimulus, prediction and result checking.
`timescale 1ns / 1ps

module hash_range_layout_check_unit_tb;
    import hrlc_pkg::*;

    localparam int QuietLimit = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Entries waiting to be offered, and layout reports waiting to come out
    t_in_item  entries_to_send[$];
    t_out_item layout_reports[$];

    // Running state of the layout being checked
    bit        first_pending;
    t_hash     wrap_edge;
    t_hash     prior_stop;
    bit        span_absent;
    t_out_item tally;

    int        mismatches = 0;
    int        results_seen = 0;
    int        cycle_no = 0;
    int        quiet_cycles = 0;
    int        hold_left = 0;

    hash_range_layout_check_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Window in which neither side idles
    function automatic bit calm_window();
        return (cycle_no >= 900) && (cycle_no < 1300);
    endfunction

    function automatic t_count step_sat(input t_count c);
        return (c == COUNT_MAX) ? c : c + t_count'(1);
    endfunction

    function automatic void clear_layout();
        first_pending = 1'b1;
        wrap_edge     = '0;
        prior_stop    = '0;
        span_absent   = 1'b1;
        tally         = '0;
    endfunction

    // Fold one accepted entry into the running layout; the last entry yields a report
    function automatic void absorb_entry(input t_in_item ent);
        t_hash     want;
        t_out_item rep;
        if (first_pending) begin
            wrap_edge     = ent.range_start - t_hash'(1);
            prior_stop    = wrap_edge;
            first_pending = 1'b0;
        end
        case (ent.err_kind)
            KIND_OK: begin
                // a collapsed range takes no part in the hole and overlap checks
                if (ent.range_start != ent.range_stop) begin
                    want        = prior_stop + t_hash'(1);
                    span_absent = 1'b0;
                    if (want < ent.range_start) tally.hole_count = step_sat(tally.hole_count);
                    if (want > ent.range_start)
                        tally.overlap_count = step_sat(tally.overlap_count);
                    prior_stop = ent.range_stop;
                end
            end
            KIND_NOT_FOUND: begin
                tally.missing_count     = step_sat(tally.missing_count);
                tally.missing_dir_count = step_sat(tally.missing_dir_count);
            end
            KIND_UNKNOWN: begin
                tally.missing_count = step_sat(tally.missing_count);
                if (ent.range_start == '0 && ent.range_stop == '0)
                    tally.missing_dir_count = step_sat(tally.missing_dir_count);
            end
            KIND_STALE:    tally.missing_count  = step_sat(tally.missing_count);
            KIND_NOT_CONN: tally.down_count     = step_sat(tally.down_count);
            KIND_NO_SPACE: tally.no_space_count = step_sat(tally.no_space_count);
            default:       tally.misc_count     = step_sat(tally.misc_count);
        endcase
        if (ent.last_entry) begin
            // wrap check, and a layout without any usable range
            if (wrap_edge != prior_stop || span_absent)
                tally.hole_count = step_sat(tally.hole_count);
            rep = tally;
            if (tally.hole_count != '0 || tally.overlap_count != '0)
                rep.verdict = VERDICT_BAD;
            else
                rep.verdict = {1'b0, tally.missing_dir_count};
            layout_reports.push_back(rep);
            clear_layout();
        end
    endfunction

    function automatic void push_entry(input t_kind k, input t_hash s, input t_hash e,
                                       input bit last);
        t_in_item ent;
        ent.err_kind    = k;
        ent.range_start = s;
        ent.range_stop  = e;
        ent.last_entry  = last;
        entries_to_send.push_back(ent);
    endfunction

    // Ranges that tile the whole hash ring from a random base, with occasional damage
    task automatic gen_clean_layout(input int n);
        longint unsigned seg, lo, hi;
        t_hash           base, s, e;
        t_kind           k;
        int              r;
        base = ($urandom_range(0, 3) == 0) ? '0 : t_hash'($urandom);
        seg  = 64'h1_0000_0000 / n;
        lo   = 0;
        for (int i = 0; i < n; i++) begin
            hi = (i == n - 1) ? 64'h1_0000_0000 : (i + 1) * seg + $urandom_range(0, seg / 2);
            s  = base + t_hash'(lo);
            e  = base + t_hash'(hi - 1);
            k  = KIND_OK;
            r  = $urandom_range(0, 99);
            if (r < 10) begin
                k = t_kind'($urandom_range(1, 7));
                if (k == KIND_UNKNOWN && $urandom_range(0, 1) == 0) begin
                    s = '0;
                    e = '0;
                end
            end else if (r < 14) begin
                s = s + t_hash'($urandom_range(1, 16));
            end else if (r < 18) begin
                s = s - t_hash'($urandom_range(1, 16));
            end else if (r < 21) begin
                e = s;
            end
            push_entry(k, s, e, i == n - 1);
            lo = hi;
        end
    endtask

    // Unordered entries with any kind and any range
    task automatic gen_noise_layout(input int n);
        t_hash s, e;
        int    r;
        for (int i = 0; i < n; i++) begin
            s = $urandom;
            e = $urandom;
            r = $urandom_range(0, 19);
            if (r < 2) e = s;
            else if (r == 2) begin
                s = '0;
                e = '0;
            end
            push_entry(t_kind'($urandom_range(0, 7)), s, e, i == n - 1);
        end
    endtask

    // Long layouts that together drive every count into saturation
    task automatic gen_flood(input int which);
        t_hash s;
        bit    last;
        for (int i = 0; i < 130; i++) begin
            last = (i == 129);
            case (which)
                0: begin
                    s = t_hash'(i) * 32'd1024;
                    push_entry(KIND_OK, s, s + 32'd15, 1'b0);
                    push_entry(KIND_NOT_FOUND, $urandom, $urandom, last);
                end
                1: begin
                    s = t_hash'(300 - i) * 32'd1024;
                    push_entry(KIND_OK, s, s + 32'd15, 1'b0);
                    push_entry(KIND_NOT_CONN, $urandom, $urandom, last);
                end
                default: begin
                    push_entry(KIND_NO_SPACE, $urandom, $urandom, 1'b0);
                    push_entry(($urandom_range(0, 1) == 0) ? KIND_OTHER : KIND_UNDEF,
                               $urandom, $urandom, last);
                end
            endcase
        end
    endtask

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) log_mismatch(what, got, want);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int flood_done;
        clear_layout();

        // single entry covering the whole ring
        push_entry(KIND_OK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        // two halves, upper half first
        push_entry(KIND_OK, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_entry(KIND_OK, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        // collapsed range at the top of the space: no usable range
        push_entry(KIND_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // errored first entry sets the wrap point; a hole, an overlap, every error kind
        push_entry(KIND_NOT_FOUND, 32'h0000_0010, 32'h0000_0020, 1'b0);
        push_entry(KIND_OK, 32'h0000_0010, 32'h0000_01FF, 1'b0);
        push_entry(KIND_OK, 32'h0000_0300, 32'h0000_03FF, 1'b0);
        push_entry(KIND_OK, 32'h0000_0380, 32'h0000_000F, 1'b0);
        push_entry(KIND_UNKNOWN, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_entry(KIND_UNKNOWN, 32'h0000_0005, 32'h0000_0000, 1'b0);
        push_entry(KIND_STALE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        push_entry(KIND_NOT_CONN, 32'h1234_5678, 32'h8765_4321, 1'b0);
        push_entry(KIND_NO_SPACE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        push_entry(KIND_OTHER, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        push_entry(KIND_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // clean ring with a missing directory: verdict is the count
        push_entry(KIND_OK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        push_entry(KIND_NOT_FOUND, 32'h0000_0000, 32'h0000_0000, 1'b1);
        // ring not closed
        push_entry(KIND_OK, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1);
        // errors only
        push_entry(KIND_NOT_CONN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        push_entry(KIND_NO_SPACE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

        // floods spread through the run, random layouts around them
        flood_done = 0;
        while (entries_to_send.size() < 1050 || flood_done < 3) begin
            if (flood_done < 3 && entries_to_send.size() >= 60 + 290 * flood_done) begin
                gen_flood(flood_done);
                flood_done++;
            end else if ($urandom_range(0, 3) == 0) begin
                gen_noise_layout($urandom_range(1, 8));
            end else begin
                gen_clean_layout(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                             : $urandom_range(1, 10));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything offered, accepted and reported
        @(negedge i_clk);
        while (entries_to_send.size() != 0 || i_in_valid || layout_reports.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && layout_reports.size() == 0)
            $display("PASS hash_range_layout_check_unit");
        else
            $display("FAIL hash_range_layout_check_unit");
        $finish;
    end

    // Entry driver: predicts on acceptance, holds a stalled item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) absorb_entry(i_in_item);
            if (!i_in_valid || !o_in_stall) begin
                if (entries_to_send.size() != 0 &&
                    (calm_window() || $urandom_range(0, 99) >= 29)) begin
                    i_in_item  <= entries_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure, with one long hold-off
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (layout_reports.size() == 0) begin
                    log_mismatch("unexpected result", o_out_item.hole_count, 0);
                end else begin
                    want = layout_reports.pop_front();
                    check_field("hole_count", o_out_item.hole_count, want.hole_count);
                    check_field("overlap_count", o_out_item.overlap_count, want.overlap_count);
                    check_field("missing_count", o_out_item.missing_count, want.missing_count);
                    check_field("down_count", o_out_item.down_count, want.down_count);
                    check_field("misc_count", o_out_item.misc_count, want.misc_count);
                    check_field("no_space_count", o_out_item.no_space_count,
                                want.no_space_count);
                    check_field("missing_dir_count", o_out_item.missing_dir_count,
                                want.missing_dir_count);
                    check_field("verdict", o_out_item.verdict, want.verdict);
                end
            end
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (cycle_no == 300) begin
            hold_left   <= 80;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm_window() && ($urandom_range(0, 99) < 29);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("FAIL hash_range_layout_check_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: files.f
sv/hrlc_pkg.sv
sv/hrlc_track.sv
sv/hash_range_layout_check_unit.sv
test/hash_range_layout_check_unit_tb.sv
